@@ rtl/core/sled_pkg.sv @@
// Package for the string literal escape decoder: item structs, result kinds,
// phase codes and the escape and hex digit lookup functions.
// No dependencies.
package sled_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_NEWLN  = 2'd2;
    localparam logic [1:0] KIND_EOI    = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;

    // Decode phases.
    typedef enum logic [4:0] {
        PH_NORMAL    = 5'b00001,
        PH_BACKSLASH = 5'b00010,
        PH_HEX0      = 5'b00100,
        PH_HEX1      = 5'b01000,
        PH_OCTAL     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_out_item;

    // Outcome of handling one byte as a plain body byte.
    typedef struct packed {
        logic      emit;
        t_out_item res;
        logic      to_bslash;
        logic      end_lit;
    } t_norm;

    // Simple escapes: {hit, decoded byte}.
    function automatic logic [8:0] esc_lookup(input logic [7:0] c);
        logic [8:0] r;
        begin
            unique case (c)
                8'h5c:   r = {1'b1, 8'h5c};
                8'h61:   r = {1'b1, 8'h07};
                8'h62:   r = {1'b1, 8'h08};
                8'h66:   r = {1'b1, 8'h0c};
                8'h6e:   r = {1'b1, 8'h0a};
                8'h72:   r = {1'b1, 8'h0d};
                8'h74:   r = {1'b1, 8'h09};
                8'h76:   r = {1'b1, 8'h0b};
                8'h22:   r = {1'b1, 8'h22};
                8'h2f:   r = {1'b1, 8'h2f};
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Hex digit: {valid, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r = {1'b1, c[3:0] + 4'd9};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    // A byte of the literal body outside any escape.
    function automatic t_norm normal_step(input logic [7:0] c, input logic eoi,
                                         input logic regex);
        t_norm r;
        logic [7:0] endc;
        begin
            endc = regex ? CH_SLASH : CH_DQUOTE;
            r = '0;
            if (eoi) begin
                r.emit = 1'b1;
                r.res.kind = KIND_EOI;
                r.end_lit = 1'b1;
            end else if (c == CH_CR) begin
                r.emit = 1'b0;
            end else if (c == endc) begin
                r.emit = 1'b1;
                r.res.kind = KIND_CLOSED;
                r.end_lit = 1'b1;
            end else if (c == CH_LF) begin
                r.emit = 1'b1;
                r.res.kind = KIND_NEWLN;
                r.end_lit = 1'b1;
            end else if (c == CH_BSLASH) begin
                r.to_bslash = 1'b1;
            end else begin
                r.emit = 1'b1;
                r.res.out_byte = c;
                r.res.kind = KIND_DATA;
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/core/string_literal_escape_decoder_core.sv @@
// Top level of the string literal escape decoder: decode logic and a
// four-entry result queue. Depends on sled_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  in       | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  out      | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_data (regex_mode)
//
// One input item is decoded in the cycle it is accepted, one item per cycle.
// Its zero, one or two results are written to the result queue and appear on
// the output from the next cycle, one per cycle; the queue sets the rate.
// Input stalls while the queue holds more than two results. The output drains
// one result per cycle, so once the queue has filled, the second result of an
// item holds back the input; every output stall adds to that.
// Synchronous reset clears the phase, mode and queue.
module string_literal_escape_decoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sled_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sled_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    sled_pkg::t_phase    r_phase, n_phase;
    logic [8:0]          r_val, n_val;
    logic [1:0]          r_cnt, n_cnt;
    logic                r_regex;

    sled_pkg::t_out_item r_fifo [4];
    logic [1:0]          r_wptr, r_rptr;
    logic [2:0]          r_count;

    logic                in_acc, out_acc;
    logic [7:0]          c;
    logic                eoi;
    logic                pre_v;
    sled_pkg::t_out_item pre;
    logic                use_norm;
    sled_pkg::t_norm     nrm, nrm_calc;
    logic [8:0]          esc;
    logic [4:0]          hd;
    logic [1:0]          n_res;
    sled_pkg::t_out_item slot0, slot1;

    assign c      = i_in_item.char_code;
    assign eoi    = i_in_item.end_of_input;
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_count > 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_item  = r_fifo[r_rptr];
    assign o_cfg_ready = 1'b1;

    assign nrm_calc = sled_pkg::normal_step(c, eoi, r_regex);
    assign esc      = sled_pkg::esc_lookup(c);
    assign hd       = sled_pkg::hex_digit(c);

    always_comb begin
        n_phase  = r_phase;
        n_val    = r_val;
        n_cnt    = r_cnt;
        pre_v    = 1'b0;
        pre      = '0;
        use_norm = 1'b0;
        nrm      = '0;
        unique case (r_phase)
            sled_pkg::PH_BACKSLASH: begin
                if (eoi) begin
                    pre_v = r_regex;
                    pre.out_byte = sled_pkg::CH_BSLASH;
                    use_norm = 1'b1;
                end else if (c == sled_pkg::CH_CR) begin
                    n_phase = sled_pkg::PH_BACKSLASH;
                end else if (c == sled_pkg::CH_LF) begin
                    n_phase = sled_pkg::PH_NORMAL;
                end else if (esc[8]) begin
                    pre_v = 1'b1;
                    pre.out_byte = esc[7:0];
                    // A decoded backslash is doubled for the regex engine.
                    nrm.emit = r_regex && (esc[7:0] == sled_pkg::CH_BSLASH);
                    nrm.res.out_byte = sled_pkg::CH_BSLASH;
                    n_phase = sled_pkg::PH_NORMAL;
                end else if (c == sled_pkg::CH_X) begin
                    n_phase = sled_pkg::PH_HEX0;
                end else if (c >= sled_pkg::CH_0 && c <= sled_pkg::CH_7) begin
                    n_val = {6'd0, c[2:0]};
                    n_cnt = 2'd1;
                    n_phase = sled_pkg::PH_OCTAL;
                end else if (c == sled_pkg::CH_8 || c == sled_pkg::CH_9) begin
                    pre_v = 1'b1;
                    pre.out_byte = c;
                    n_phase = sled_pkg::PH_NORMAL;
                end else begin
                    pre_v = r_regex;
                    pre.out_byte = sled_pkg::CH_BSLASH;
                    use_norm = 1'b1;
                end
            end
            sled_pkg::PH_HEX0: begin
                if (!eoi && c == sled_pkg::CH_CR) begin
                    n_phase = sled_pkg::PH_HEX0;
                end else if (!eoi && hd[4]) begin
                    n_val = {5'd0, hd[3:0]};
                    n_phase = sled_pkg::PH_HEX1;
                end else begin
                    pre_v = 1'b1;
                    pre.out_byte = sled_pkg::CH_X;
                    use_norm = 1'b1;
                end
            end
            sled_pkg::PH_HEX1: begin
                if (!eoi && c == sled_pkg::CH_CR) begin
                    n_phase = sled_pkg::PH_HEX1;
                end else if (!eoi && hd[4]) begin
                    pre_v = 1'b1;
                    pre.out_byte = {r_val[3:0], hd[3:0]};
                    n_val = 9'd0;
                    n_phase = sled_pkg::PH_NORMAL;
                end else begin
                    pre_v = 1'b1;
                    pre.out_byte = r_val[7:0];
                    n_val = 9'd0;
                    use_norm = 1'b1;
                end
            end
            sled_pkg::PH_OCTAL: begin
                if (!eoi && c == sled_pkg::CH_CR) begin
                    n_phase = sled_pkg::PH_OCTAL;
                end else if (!eoi && c >= sled_pkg::CH_0 && c <= sled_pkg::CH_7
                             && r_cnt != 2'd3) begin
                    if (r_cnt == 2'd2) begin
                        // Third digit: the value goes out at once.
                        pre_v = 1'b1;
                        pre.out_byte = {r_val[4:0], c[2:0]};
                        n_val = 9'd0;
                        n_cnt = 2'd0;
                        n_phase = sled_pkg::PH_NORMAL;
                    end else begin
                        n_val = {r_val[5:0], c[2:0]};
                        n_cnt = r_cnt + 2'd1;
                    end
                end else begin
                    pre_v = 1'b1;
                    pre.out_byte = r_val[7:0];
                    n_val = 9'd0;
                    n_cnt = 2'd0;
                    use_norm = 1'b1;
                end
            end
            default: begin
                use_norm = 1'b1;
            end
        endcase

        // The terminating byte of an escape is handled again as a body byte.
        if (use_norm) begin
            nrm = nrm_calc;
            n_phase = nrm_calc.to_bslash ? sled_pkg::PH_BACKSLASH : sled_pkg::PH_NORMAL;
            if (nrm_calc.end_lit) begin
                n_val = 9'd0;
                n_cnt = 2'd0;
            end
        end

        slot0 = '0;
        slot1 = '0;
        if (pre_v) begin
            slot0 = pre;
            slot1 = nrm.res;
            n_res = nrm.emit ? 2'd2 : 2'd1;
        end else begin
            slot0 = nrm.res;
            n_res = nrm.emit ? 2'd1 : 2'd0;
        end
        if (n_res == 2'd2) begin
            slot1.last = 1'b1;
        end else begin
            slot0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sled_pkg::PH_NORMAL;
            r_val   <= 9'd0;
            r_cnt   <= 2'd0;
            r_regex <= 1'b0;
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_regex <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase <= n_phase;
                r_val   <= n_val;
                r_cnt   <= n_cnt;
                r_wptr  <= r_wptr + n_res;
            end
            if (out_acc) begin
                r_rptr <= r_rptr + 2'd1;
            end
            r_count <= r_count + (in_acc ? {1'b0, n_res} : 3'd0)
                       - (out_acc ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res != 2'd0) begin
            r_fifo[r_wptr] <= slot0;
        end
        if (in_acc && n_res == 2'd2) begin
            r_fifo[r_wptr + 2'd1] <= slot1;
        end
    end

endmodule

@@ tb/string_literal_escape_decoder_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for string_literal_escape_decoder_core: directed and random
// literal bodies in string and regex mode, checked against an in-bench decoder model.
// Depends on sled_pkg and the decoder RTL.
module string_literal_escape_decoder_core_tb;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    sled_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                i_cfg_data  = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_cfg_ready;
    sled_pkg::t_out_item o_out_item;

    string_literal_escape_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Decoder model state.
    logic             regex_on    = 1'b0;
    sled_pkg::t_phase lit_phase   = sled_pkg::PH_NORMAL;
    logic [8:0]       gathered    = 9'd0;
    logic [1:0]       digit_count = 2'd0;

    sled_pkg::t_out_item item_results[$];
    sled_pkg::t_out_item pending_decoded[$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int n_items    = 0;
    int n_results  = 0;
    int n_mismatch = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            sled_pkg::CH_BSLASH: return {1'b1, sled_pkg::CH_BSLASH};
            "a":                 return {1'b1, 8'h07};
            "b":                 return {1'b1, 8'h08};
            "f":                 return {1'b1, 8'h0c};
            "n":                 return {1'b1, 8'h0a};
            "r":                 return {1'b1, 8'h0d};
            "t":                 return {1'b1, 8'h09};
            "v":                 return {1'b1, 8'h0b};
            sled_pkg::CH_DQUOTE: return {1'b1, sled_pkg::CH_DQUOTE};
            sled_pkg::CH_SLASH:  return {1'b1, sled_pkg::CH_SLASH};
            default:             return 9'd0;
        endcase
    endfunction

    // Returns {is_hex_digit, value}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= sled_pkg::CH_0 && c <= sled_pkg::CH_9) begin
            return {1'b1, 4'(c - sled_pkg::CH_0)};
        end else if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic put_result(input logic [7:0] b, input logic [1:0] k);
        sled_pkg::t_out_item r;
        r.out_byte = (k == sled_pkg::KIND_DATA) ? b : 8'h00;
        r.kind     = k;
        r.last     = 1'b0;
        if (item_results.size() < 2) item_results.push_back(r);
    endtask

    task automatic close_literal(input logic [1:0] k);
        put_result(8'h00, k);
        lit_phase   = sled_pkg::PH_NORMAL;
        gathered    = 9'd0;
        digit_count = 2'd0;
    endtask

    task automatic body_byte(input logic [7:0] c, input logic eoi);
        lit_phase = sled_pkg::PH_NORMAL;
        if (eoi) begin
            close_literal(sled_pkg::KIND_EOI);
        end else if (c == sled_pkg::CH_CR) begin
        end else if (c == (regex_on ? sled_pkg::CH_SLASH : sled_pkg::CH_DQUOTE)) begin
            close_literal(sled_pkg::KIND_CLOSED);
        end else if (c == sled_pkg::CH_LF) begin
            close_literal(sled_pkg::KIND_NEWLN);
        end else if (c == sled_pkg::CH_BSLASH) begin
            lit_phase = sled_pkg::PH_BACKSLASH;
        end else begin
            put_result(c, sled_pkg::KIND_DATA);
        end
    endtask

    task automatic after_escape(input logic [7:0] c, input logic eoi);
        logic [8:0] se;
        se = simple_escape(c);
        if (eoi) begin
            if (regex_on) put_result(sled_pkg::CH_BSLASH, sled_pkg::KIND_DATA);
            body_byte(c, eoi);
        end else if (c == sled_pkg::CH_CR) begin
        end else if (c == sled_pkg::CH_LF) begin
            lit_phase = sled_pkg::PH_NORMAL;
        end else if (se[8]) begin
            put_result(se[7:0], sled_pkg::KIND_DATA);
            if (regex_on && se[7:0] == sled_pkg::CH_BSLASH) begin
                put_result(sled_pkg::CH_BSLASH, sled_pkg::KIND_DATA);
            end
            lit_phase = sled_pkg::PH_NORMAL;
        end else if (c == sled_pkg::CH_X) begin
            lit_phase = sled_pkg::PH_HEX0;
        end else if (c >= sled_pkg::CH_0 && c <= sled_pkg::CH_7) begin
            gathered    = {6'd0, c[2:0]};
            digit_count = 2'd1;
            lit_phase   = sled_pkg::PH_OCTAL;
        end else if (c == sled_pkg::CH_8 || c == sled_pkg::CH_9) begin
            put_result(c, sled_pkg::KIND_DATA);
            lit_phase = sled_pkg::PH_NORMAL;
        end else begin
            // Unknown escape: regex mode keeps the backslash.
            if (regex_on) put_result(sled_pkg::CH_BSLASH, sled_pkg::KIND_DATA);
            body_byte(c, eoi);
        end
    endtask

    task automatic decode_item(input sled_pkg::t_in_item it);
        logic [7:0]          c;
        logic                eoi;
        logic [4:0]          hv;
        sled_pkg::t_out_item r;
        c   = it.char_code;
        eoi = it.end_of_input;
        hv  = eoi ? 5'd0 : hex_value(c);
        item_results.delete();
        case (lit_phase)
            sled_pkg::PH_BACKSLASH: begin
                after_escape(c, eoi);
            end
            sled_pkg::PH_HEX0: begin
                if (eoi || c != sled_pkg::CH_CR) begin
                    if (hv[4]) begin
                        gathered  = {5'd0, hv[3:0]};
                        lit_phase = sled_pkg::PH_HEX1;
                    end else begin
                        put_result(sled_pkg::CH_X, sled_pkg::KIND_DATA);
                        body_byte(c, eoi);
                    end
                end
            end
            sled_pkg::PH_HEX1: begin
                if (eoi || c != sled_pkg::CH_CR) begin
                    if (hv[4]) begin
                        put_result({gathered[3:0], hv[3:0]}, sled_pkg::KIND_DATA);
                        gathered  = 9'd0;
                        lit_phase = sled_pkg::PH_NORMAL;
                    end else begin
                        // The terminating byte is handled again as a body byte.
                        put_result(gathered[7:0], sled_pkg::KIND_DATA);
                        gathered = 9'd0;
                        body_byte(c, eoi);
                    end
                end
            end
            sled_pkg::PH_OCTAL: begin
                if (!eoi && c == sled_pkg::CH_CR) begin
                end else if (!eoi && c >= sled_pkg::CH_0 && c <= sled_pkg::CH_7
                             && digit_count < 2'd3) begin
                    gathered    = {gathered[5:0], c[2:0]};
                    digit_count = digit_count + 2'd1;
                    if (digit_count == 2'd3) begin
                        put_result(gathered[7:0], sled_pkg::KIND_DATA);
                        gathered    = 9'd0;
                        digit_count = 2'd0;
                        lit_phase   = sled_pkg::PH_NORMAL;
                    end
                end else begin
                    put_result(gathered[7:0], sled_pkg::KIND_DATA);
                    gathered    = 9'd0;
                    digit_count = 2'd0;
                    body_byte(c, eoi);
                end
            end
            default: begin
                body_byte(c, eoi);
            end
        endcase
        foreach (item_results[i]) begin
            r      = item_results[i];
            r.last = (i == item_results.size() - 1);
            pending_decoded.push_back(r);
        end
    endtask

    // ------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : check_results
        sled_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_decoded.size() == 0) begin
                report_mismatch($sformatf("unexpected result: byte %02h kind %0d last %0b",
                    o_out_item.out_byte, o_out_item.kind, o_out_item.last));
            end else begin
                want = pending_decoded.pop_front();
                if (o_out_item.out_byte !== want.out_byte || o_out_item.kind !== want.kind
                        || o_out_item.last !== want.last) begin
                    report_mismatch({
                        $sformatf("result %0d: expected byte %02h kind %0d last %0b,",
                            n_results, want.out_byte, want.kind, want.last),
                        $sformatf(" got byte %02h kind %0d last %0b",
                            o_out_item.out_byte, o_out_item.kind, o_out_item.last)});
                end
            end
        end
    end

    // Receiver stalls in random bursts.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_idle && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------- driving

    task automatic send_item(input sled_pkg::t_in_item it);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        decode_item(it);
        n_items++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(sled_pkg::t_in_item'{char_code: c, end_of_input: 1'b0});
    endtask

    task automatic send_eoi();
        send_item(sled_pkg::t_in_item'{char_code: 8'($urandom_range(0, 255)),
                                       end_of_input: 1'b1});
    endtask

    // Holds the input until every expected result has come out, then lets the
    // queue settle in case the last items produced nothing.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_decoded.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        regex_on = m;
    endtask

    function automatic logic [7:0] escape_char(input int sel);
        case (sel)
            0:       return sled_pkg::CH_BSLASH;
            1:       return "a";
            2:       return "b";
            3:       return "f";
            4:       return "n";
            5:       return "r";
            6:       return "t";
            7:       return "v";
            8:       return sled_pkg::CH_DQUOTE;
            default: return sled_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] random_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'(sled_pkg::CH_0 + v);
        if (v < 16) return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    // One piece of a literal body: mostly plain bytes and well-formed escapes,
    // with delimiters, newlines and end of input mixed in.
    task automatic send_token();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_char(8'($urandom_range(0, 255)));
        end else if (pick < 50) begin
            send_char(8'($urandom_range(8'h20, 8'h7e)));
        end else if (pick < 60) begin
            send_char(sled_pkg::CH_BSLASH);
            send_char(escape_char($urandom_range(0, 9)));
        end else if (pick < 70) begin
            send_char(sled_pkg::CH_BSLASH);
            send_char(sled_pkg::CH_X);
            k = $urandom_range(0, 2);
            repeat (k) send_char(random_hex());
        end else if (pick < 80) begin
            send_char(sled_pkg::CH_BSLASH);
            k = $urandom_range(1, 3);
            repeat (k) send_char(8'(sled_pkg::CH_0 + $urandom_range(0, 7)));
        end else if (pick < 84) begin
            send_char(sled_pkg::CH_BSLASH);
            send_char(8'($urandom_range(0, 255)));
        end else if (pick < 89) begin
            send_char(sled_pkg::CH_CR);
        end else if (pick < 94) begin
            send_char($urandom_range(0, 1) ? sled_pkg::CH_SLASH : sled_pkg::CH_DQUOTE);
        end else if (pick < 97) begin
            send_char(sled_pkg::CH_LF);
        end else begin
            send_eoi();
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_plain_bytes();
        send_char(8'h00);
        send_char(8'hff);
        send_char(sled_pkg::CH_CR);
    endtask

    task automatic test_string_escapes();
        // Hex escape with a carriage return dropped between its digits.
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_X); send_char("4");
        send_char(sled_pkg::CH_CR); send_char("F");
        // Backslash-x with no digit gives 'x', and the quote then closes the literal.
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_X);
        send_char(sled_pkg::CH_DQUOTE);
        // Three octal digits emit at once; the value is cut to eight bits.
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_7);
        send_char(sled_pkg::CH_7); send_char(sled_pkg::CH_7);
        // A newline ends a one-digit octal escape and then the literal.
        send_char(sled_pkg::CH_BSLASH); send_char("1"); send_char(sled_pkg::CH_LF);
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_9);
        send_char(sled_pkg::CH_BSLASH); send_char("q");
        // Line continuation produces nothing.
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_LF);
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_X); send_char("A");
        send_eoi();
    endtask

    task automatic test_regex_escapes();
        write_mode(1'b1);
        send_char(sled_pkg::CH_BSLASH); send_char(sled_pkg::CH_BSLASH);
        send_char(sled_pkg::CH_BSLASH); send_char("q");
        send_char(sled_pkg::CH_BSLASH); send_eoi();
        send_char(sled_pkg::CH_SLASH);
    endtask

    task automatic test_mode_switch_mid_literal();
        send_char(sled_pkg::CH_BSLASH);
        write_mode(1'b0);
        send_char(sled_pkg::CH_SLASH);
        // In string mode end of input after a backslash gives only the status.
        send_char(sled_pkg::CH_BSLASH); send_eoi();
    endtask

    task automatic test_random_phase(input int count, input logic m, input bit idle);
        int target;
        write_mode(m);
        tx_idle = idle;
        rx_idle = idle;
        target  = n_items + count;
        while (n_items < target) send_token();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_bytes();
        test_string_escapes();
        test_regex_escapes();
        test_mode_switch_mid_literal();
        test_random_phase(200, 1'b0, 1'b1);
        test_random_phase(200, 1'b1, 1'b1);
        test_random_phase(150, 1'b0, 1'b1);
        test_random_phase(200, 1'b1, 1'b0);

        drain_results();
        $display("Sent %0d input items in string and regex mode and checked %0d results;",
            n_items, n_results);
        $display("mismatches: %0d", n_mismatch);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ string_literal_escape_decoder_core.f @@
rtl/core/sled_pkg.sv
rtl/core/string_literal_escape_decoder_core.sv
tb/string_literal_escape_decoder_core_tb.sv
